### hdl/wesm_pkg.sv
// shared types and constants for the windowed error statistics monitor
`default_nettype none
package wesm_pkg;
    localparam int RING_DEPTH = 1024;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [47:0] INTEGRAL_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] CFG_WINDOW = 3'd0;
    localparam logic [2:0] CFG_ENABLE = 3'd1;
    localparam logic [2:0] CFG_WARN = 3'd2;
    localparam logic [2:0] CFG_ERROR = 3'd3;
    localparam logic [2:0] CFG_CRIT = 3'd4;

    localparam logic REQ_CLEAR = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input word
        logic clear;      // empty window
        logic drop_full;  // drop oldest because ring full
        logic write;      // store sample
        logic evict_rd;   // issue read at oldest slot
        logic evict_pop;  // pop oldest entry
        logic walk_init;  // reset accumulators
        logic walk_rd;    // issue read at walk index
        logic walk_acc;   // accumulate returned entry
        logic div_start;  // start dividers
        logic sqrt_start; // start square root
        logic finish;     // form result word
    } wesm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_clear;
        logic full;
        logic empty;
        logic too_old;
        logic walk_done;
        logic div_done;
        logic sqrt_done;
    } wesm_sts_t;
endpackage
`default_nettype wire

### hdl/windowed_error_statistics_monitor.sv
// top level of the windowed error statistics monitor
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; each gives exactly
// one result word on m_tvalid/m_tready/m_tdata. A word adds a timestamped
// Q3.12 error sample to a 1024 entry ring or, with req_type set, clears the
// window. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle; the block itself does not enforce
// this. One word at a time is handled: add, eviction check of the oldest
// entry (read, wait and check states per evicted entry and for the entry
// that stays), a walk over the ring (one entry per cycle, single port ram),
// a divider for mean and mean square and a square root. s_tready is high
// only while idle. When the receiver stalls the result word holds on
// m_tdata and no new word is taken. Reset empties the window and loads the
// default configuration; ring contents need no clearing.
`default_nettype none
module windowed_error_statistics_monitor (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sample_time_us[31:0], error_value[47:32]
    input  wire logic [47:0]  s_tdata,
    // req_type
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rms_error[15:0], peak_magnitude[31:16], mean_value[47:32],
    // magnitude_integral[95:48], window_count[106:96], severity[108:107],
    // colour_class[110:109]
    output logic [111:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [26:0]  cfg_data
);
    import wesm_pkg::*;

    wesm_cmd_t    cmd;
    wesm_sts_t    sts;
    logic [111:0] res;

    wesm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .sts(sts)
    );

    wesm_dp u_dp (
        .clk(clk), .rst_n(rst_n), .s_tdata({s_tdata, s_tuser}), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .m_tdata(res)
    );

    assign m_tdata = res;
endmodule
`default_nettype wire

### hdl/wesm_ram.sv
// generic single port ram with registered read
`default_nettype none
module wesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hdl/wesm_ctrl.sv
// sequencing state machine for the statistics monitor
`default_nettype none
module wesm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output wesm_pkg::wesm_cmd_t      cmd,
    input  wire wesm_pkg::wesm_sts_t sts
);
    import wesm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD = 4'd1;
    localparam logic [3:0] S_EV_RD = 4'd2;
    localparam logic [3:0] S_EV_WAIT = 4'd3;
    localparam logic [3:0] S_EV_CHK = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (sts.is_clear)
                begin
                    cmd.clear = 1'b1;
                    state_next = S_WALK;
                    cmd.walk_init = 1'b1;
                end
                else
                begin
                    cmd.drop_full = sts.full;
                    cmd.write = 1'b1;
                    state_next = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                if (sts.empty)
                begin
                    cmd.walk_init = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.evict_rd = 1'b1;
                    state_next = S_EV_WAIT;
                end
            end
            S_EV_WAIT:
            begin
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                if (sts.too_old)
                begin
                    cmd.evict_pop = 1'b1;
                    state_next = S_EV_RD;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_rd = 1'b1;
                cmd.walk_acc = 1'b1;
                if (sts.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/wesm_dp.sv
// ring storage, window walk, dividers and square root
`default_nettype none
module wesm_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [48:0]         s_tdata,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [26:0]         cfg_data,
    input  wire wesm_pkg::wesm_cmd_t cmd,
    output wesm_pkg::wesm_sts_t      sts,
    output logic [111:0]             m_tdata
);
    import wesm_pkg::*;

    // configuration registers
    logic [26:0] win_reg;
    logic [2:0]  en_reg;
    logic [14:0] warn_reg, err_reg, crit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 27'd1000000;
            en_reg <= 3'd7;
            warn_reg <= 15'd205;
            err_reg <= 15'd410;
            crit_reg <= 15'd819;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW: win_reg <= cfg_data;
                CFG_ENABLE: en_reg <= cfg_data[2:0];
                CFG_WARN: warn_reg <= cfg_data[14:0];
                CFG_ERROR: err_reg <= cfg_data[14:0];
                CFG_CRIT: crit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // captured input word
    logic        req_reg;
    logic [31:0] t_reg;
    logic signed [15:0] cur_reg;
    logic [16:0] cur_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= s_tdata[0];
            t_reg <= s_tdata[32:1];
            cur_reg <= s_tdata[48:33];
        end
        else if (cmd.clear)
        begin
            cur_reg <= '0;
        end
    end

    assign cur_mag = cur_reg[15] ? 17'(-$signed({cur_reg[15], cur_reg}))
                                 : {1'b0, cur_reg};

    // window start, signed 34 bit
    logic signed [33:0] start;
    assign start = $signed({2'b00, t_reg}) - $signed({7'd0, win_reg});

    // ring pointers
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] walk_reg;
    logic          acc_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.clear)
        begin
            oldest_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.write)
        begin
            if (cmd.drop_full)
            begin
                oldest_reg <= oldest_reg + AW'(1);
            end
            else
            begin
                fill_reg <= fill_reg + CW'(1);
            end
        end
        else if (cmd.evict_pop)
        begin
            oldest_reg <= oldest_reg + AW'(1);
            fill_reg <= fill_reg - CW'(1);
        end
    end

    // ram address selection
    logic [AW-1:0] wr_slot, addr;
    logic [31:0]   st_rd;
    logic [15:0]   va_rd;
    assign wr_slot = oldest_reg + fill_reg[AW-1:0];
    always_comb
    begin
        if (cmd.write)
        begin
            addr = wr_slot;
        end
        else if (cmd.walk_rd)
        begin
            addr = oldest_reg + walk_reg[AW-1:0];
        end
        else
        begin
            addr = oldest_reg;
        end
    end

    wesm_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_stamp (
        .clk(clk), .we(cmd.write), .addr(addr), .wdata(t_reg), .rdata(st_rd)
    );
    wesm_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_value (
        .clk(clk), .we(cmd.write), .addr(addr), .wdata(cur_reg), .rdata(va_rd)
    );

    logic rd_old;
    assign rd_old = $signed({2'b00, st_rd}) < start;

    // walk accumulators
    logic signed [25:0] sum_reg;
    logic [40:0] sumsq_reg;
    logic [47:0] integ_reg;
    logic [15:0] peak_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] last_reg;
    logic [16:0] mag;
    logic [31:0] dt;
    logic [48:0] add, isum;
    assign mag = va_rd[15] ? 17'(-$signed({va_rd[15], va_rd})) : {1'b0, va_rd};
    assign dt = st_rd - last_reg;
    assign add = 49'(mag * dt);
    assign isum = {1'b0, integ_reg} + add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
            acc_vld_reg <= 1'b0;
        end
        else if (cmd.walk_init)
        begin
            walk_reg <= '0;
            acc_vld_reg <= 1'b0;
        end
        else if (cmd.walk_acc)
        begin
            acc_vld_reg <= (walk_reg < fill_reg);
            if (walk_reg < fill_reg)
            begin
                walk_reg <= walk_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            sum_reg <= '0;
            sumsq_reg <= '0;
            integ_reg <= '0;
            peak_reg <= '0;
            cnt_reg <= '0;
            last_reg <= '0;
        end
        else if (cmd.walk_acc && acc_vld_reg && !rd_old)
        begin
            sum_reg <= sum_reg + 26'($signed(va_rd));
            sumsq_reg <= sumsq_reg + 41'(mag * mag);
            if (mag > {1'b0, peak_reg})
            begin
                peak_reg <= mag[15:0];
            end
            if (cnt_reg != '0 && st_rd > last_reg)
            begin
                integ_reg <= isum[48] ? INTEGRAL_MAX : isum[47:0];
            end
            last_reg <= st_rd;
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // restoring dividers for mean and mean square, one bit a cycle
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [40:0] q2_reg;
    logic [CW:0] r2_reg;
    logic [25:0] q1_reg;
    logic [CW:0] r1_reg;
    logic        neg_reg;
    logic [CW:0] r2s, r1s;
    assign r2s = {r2_reg[CW-1:0], q2_reg[40]};
    assign r1s = {r1_reg[CW-1:0], q1_reg[25]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= (cnt_reg != '0);
            dcnt_reg <= 6'd41;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dcnt_reg == 6'd1)
            begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            q2_reg <= sumsq_reg;
            r2_reg <= '0;
            q1_reg <= sum_reg[25] ? 26'(-sum_reg) : sum_reg[25:0];
            r1_reg <= '0;
            neg_reg <= sum_reg[25];
        end
        else if (dbusy_reg)
        begin
            if (r2s >= {1'b0, cnt_reg})
            begin
                r2_reg <= r2s - {1'b0, cnt_reg};
                q2_reg <= {q2_reg[39:0], 1'b1};
            end
            else
            begin
                r2_reg <= r2s;
                q2_reg <= {q2_reg[39:0], 1'b0};
            end
            if (dcnt_reg <= 6'd26)
            begin
                if (r1s >= {1'b0, cnt_reg})
                begin
                    r1_reg <= r1s - {1'b0, cnt_reg};
                    q1_reg <= {q1_reg[24:0], 1'b1};
                end
                else
                begin
                    r1_reg <= r1s;
                    q1_reg <= {q1_reg[24:0], 1'b0};
                end
            end
        end
    end

    // bit pair square root of the mean square
    logic [4:0]  scnt_reg;
    logic        sbusy_reg;
    logic [39:0] sv_reg;
    logic [21:0] srem_reg;
    logic [19:0] root_reg;
    logic [21:0] strial, snext;
    assign snext = {srem_reg[19:0], sv_reg[39:38]};
    assign strial = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg <= 1'b0;
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sbusy_reg <= 1'b1;
            scnt_reg <= 5'd20;
        end
        else if (sbusy_reg)
        begin
            scnt_reg <= scnt_reg - 5'd1;
            if (scnt_reg == 5'd1)
            begin
                sbusy_reg <= 1'b0;
            end
        end
    end

    // mean square never exceeds 2^30, so the low 40 quotient bits carry it
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sv_reg <= (cnt_reg == '0) ? 40'd0 : q2_reg[39:0];
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            sv_reg <= {sv_reg[37:0], 2'b00};
            if (snext >= strial)
            begin
                srem_reg <= snext - strial;
                root_reg <= {root_reg[18:0], 1'b1};
            end
            else
            begin
                srem_reg <= snext;
                root_reg <= {root_reg[18:0], 1'b0};
            end
        end
    end

    // result word
    logic [15:0] rms, peak, mean;
    logic [47:0] integ;
    logic [1:0]  sev, colour;
    logic [25:0] mq;
    assign mq = neg_reg ? 26'(-q1_reg) : q1_reg;
    assign rms = en_reg[0] ? root_reg[15:0] : 16'd0;
    assign peak = (en_reg[1] && cnt_reg != '0) ? peak_reg : 16'd0;
    assign integ = (en_reg[2] && cnt_reg != '0) ? integ_reg : 48'd0;
    assign mean = (cnt_reg != '0) ? mq[15:0] : 16'd0;

    always_comb
    begin
        if (rms >= {1'b0, crit_reg}) sev = 2'd3;
        else if (rms >= {1'b0, err_reg}) sev = 2'd2;
        else if (rms >= {1'b0, warn_reg}) sev = 2'd1;
        else sev = 2'd0;
        if (cur_mag < {2'b00, warn_reg}) colour = 2'd0;
        else if (cur_mag < {2'b00, err_reg}) colour = 2'd1;
        else colour = 2'd2;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata <= {1'b0, colour, sev, cnt_reg, integ, mean, peak, rms};
        end
    end

    // status back to the controller
    assign sts.is_clear = (req_reg == REQ_CLEAR);
    assign sts.full = (fill_reg == CW'(RING_DEPTH));
    assign sts.empty = (fill_reg == '0);
    assign sts.too_old = rd_old;
    assign sts.walk_done = cmd.walk_acc && !acc_vld_reg && walk_reg != '0
                           || (fill_reg == '0 && walk_reg == '0 && !acc_vld_reg
                               && cmd.walk_acc && 1'b1);
    assign sts.div_done = !dbusy_reg;
    assign sts.sqrt_done = !sbusy_reg && !cmd.sqrt_start;
endmodule
`default_nettype wire
